[src/rdq_pkg.sv]
// shared types and constants for the reversible deque
// no dependencies
package rdq_pkg;

  localparam int DEPTH       = 16;
  localparam int DATA_WIDTH  = 64;
  localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int SUM_W       = ADDR_W + 1;
  localparam int PORT_DATA_W = 64;
  localparam int PORT_CNT_W  = 5;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_READ_FRONT = 3'd4,
    CMD_READ_BACK  = 3'd5,
    CMD_REVERSE    = 3'd6,
    CMD_CLEAR      = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_t;

endpackage

[src/rdq_ctrl.sv]
// controller state machine: handshake and sequencing of one command
// depends on rdq_pkg
module rdq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  output logic            out_valid,
  output rdq_pkg::ctrl_t  ctl
);

  rdq_pkg::state_t state_r;
  rdq_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rdq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rdq_pkg::S_IDLE: begin
        if (start) state_nxt = rdq_pkg::S_EXEC;
      end
      rdq_pkg::S_EXEC: begin
        state_nxt = rdq_pkg::S_DONE;
      end
      rdq_pkg::S_DONE: begin
        state_nxt = start ? rdq_pkg::S_EXEC : rdq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = rdq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy      = 1'b0;
    out_valid = 1'b0;
    ctl.exec  = 1'b0;
    unique case (state_r)
      rdq_pkg::S_IDLE: begin
      end
      rdq_pkg::S_EXEC: begin
        busy     = 1'b1;
        ctl.exec = 1'b1;
      end
      rdq_pkg::S_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
      end
    endcase
    ctl.load = start && !busy;
  end

`ifndef SYNTHESIS
  a_valid_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> (ctl.exec && busy))
    else $error("accepted transaction not executed next cycle");
`endif

endmodule

[src/rdq_dp.sv]
// datapath: ring store, head pointer, count, reversed flag and result registers
// depends on rdq_pkg
module rdq_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rdq_pkg::ctrl_t                   ctl,
  input  logic [2:0]                       in_command,
  input  logic [rdq_pkg::PORT_DATA_W-1:0]  in_data_in,
  output logic [rdq_pkg::PORT_DATA_W-1:0]  out_data_out,
  output logic [1:0]                       out_status,
  output logic [rdq_pkg::PORT_CNT_W-1:0]   out_count_out,
  output logic                             out_is_empty
);

  logic [rdq_pkg::DATA_WIDTH-1:0] mem [rdq_pkg::DEPTH];

  rdq_pkg::cmd_t                  cmd_r;
  logic [rdq_pkg::DATA_WIDTH-1:0] data_r;
  logic [rdq_pkg::ADDR_W-1:0]     head_r, head_nxt;
  logic [rdq_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic                           rev_r, rev_nxt;
  logic [rdq_pkg::DATA_WIDTH-1:0] rd_data_r;
  logic                           take_r, take_nxt;
  rdq_pkg::status_t               status_r, status_nxt;

  logic                           phys_back;
  logic                           is_full;
  logic                           is_zero;
  logic [rdq_pkg::SUM_W-1:0]      tail_sum, last_sum;
  logic [rdq_pkg::ADDR_W-1:0]     tail_addr, last_addr, head_dec, head_inc;
  logic [rdq_pkg::ADDR_W-1:0]     rd_addr, wr_addr;
  logic                           wr_en;

  // slot arithmetic, all sums stay below twice the depth
  always_comb begin
    tail_sum = rdq_pkg::SUM_W'(head_r) + rdq_pkg::SUM_W'(count_r);
    last_sum = tail_sum - rdq_pkg::SUM_W'(1);
    if (tail_sum >= rdq_pkg::SUM_W'(rdq_pkg::DEPTH))
      tail_addr = rdq_pkg::ADDR_W'(tail_sum - rdq_pkg::SUM_W'(rdq_pkg::DEPTH));
    else
      tail_addr = rdq_pkg::ADDR_W'(tail_sum);
    if (last_sum >= rdq_pkg::SUM_W'(rdq_pkg::DEPTH))
      last_addr = rdq_pkg::ADDR_W'(last_sum - rdq_pkg::SUM_W'(rdq_pkg::DEPTH));
    else
      last_addr = rdq_pkg::ADDR_W'(last_sum);
    head_dec = (head_r == '0) ? rdq_pkg::ADDR_W'(rdq_pkg::DEPTH - 1)
                              : head_r - rdq_pkg::ADDR_W'(1);
    head_inc = (head_r == rdq_pkg::ADDR_W'(rdq_pkg::DEPTH - 1)) ? '0
                              : head_r + rdq_pkg::ADDR_W'(1);
  end

  assign phys_back = cmd_r[0] ^ rev_r;
  assign is_full   = (count_r == rdq_pkg::CNT_W'(rdq_pkg::DEPTH));
  assign is_zero   = (count_r == '0);
  assign rd_addr   = phys_back ? last_addr : head_r;

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    rev_nxt    = rev_r;
    take_nxt   = 1'b0;
    status_nxt = rdq_pkg::ST_OK;
    wr_en      = 1'b0;
    wr_addr    = tail_addr;
    unique case (cmd_r)
      rdq_pkg::CMD_PUSH_FRONT, rdq_pkg::CMD_PUSH_BACK: begin
        if (is_full) begin
          status_nxt = rdq_pkg::ST_FULL;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + rdq_pkg::CNT_W'(1);
          if (!phys_back) begin
            wr_addr  = head_dec;
            head_nxt = head_dec;
          end
        end
      end
      rdq_pkg::CMD_POP_FRONT, rdq_pkg::CMD_POP_BACK: begin
        if (is_zero) begin
          status_nxt = rdq_pkg::ST_EMPTY;
        end else begin
          take_nxt  = 1'b1;
          count_nxt = count_r - rdq_pkg::CNT_W'(1);
          if (!phys_back) head_nxt = head_inc;
        end
      end
      rdq_pkg::CMD_READ_FRONT, rdq_pkg::CMD_READ_BACK: begin
        if (is_zero) status_nxt = rdq_pkg::ST_EMPTY;
        else         take_nxt   = 1'b1;
      end
      rdq_pkg::CMD_REVERSE: begin
        rev_nxt = !rev_r;
      end
      rdq_pkg::CMD_CLEAR: begin
        head_nxt  = '0;
        count_nxt = '0;
        rev_nxt   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // command capture
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= rdq_pkg::cmd_t'(in_command);
      data_r <= in_data_in[rdq_pkg::DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      rev_r   <= 1'b0;
    end else if (ctl.exec) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      take_r   <= take_nxt;
      status_r <= status_nxt;
    end
  end

  // ring store, at most one write and one registered read per command
  always_ff @(posedge clk) begin
    if (ctl.exec && wr_en) mem[wr_addr] <= data_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) rd_data_r <= mem[rd_addr];
  end

  assign out_data_out  = take_r ? rdq_pkg::PORT_DATA_W'(rd_data_r) : '0;
  assign out_status    = status_r;
  assign out_count_out = rdq_pkg::PORT_CNT_W'(count_r);
  assign out_is_empty  = is_zero;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= rdq_pkg::CNT_W'(rdq_pkg::DEPTH))
    else $error("word count above depth");

  a_full_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.exec && is_full && !cmd_r[2] && !cmd_r[1]) |=>
      ($stable(count_r) && $stable(head_r) && status_r == rdq_pkg::ST_FULL))
    else $error("push on full queue changed state");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.exec && cmd_r == rdq_pkg::CMD_CLEAR) |=>
      (count_r == '0 && head_r == '0 && !rev_r))
    else $error("clear left state behind");
`endif

endmodule

[src/reversible_deque.sv]
// reversible deque: one command accepted when start is high and busy is low,
// a result strobed on out_valid in the done state after the execute state;
// a new command is not taken until the last has left its execute state,
// in which busy holds off the next command
// synchronous active-low reset empties the queue and clears the reversed flag;
// stored words are not cleared. the receiver cannot stall results
module reversible_deque (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [2:0]                       in_command,
  input  logic [rdq_pkg::PORT_DATA_W-1:0]  in_data_in,
  output logic                             out_valid,
  output logic [rdq_pkg::PORT_DATA_W-1:0]  out_data_out,
  output logic [1:0]                       out_status,
  output logic [rdq_pkg::PORT_CNT_W-1:0]   out_count_out,
  output logic                             out_is_empty
);

  rdq_pkg::ctrl_t ctl;

  rdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  rdq_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .in_command    (in_command),
    .in_data_in    (in_data_in),
    .out_data_out  (out_data_out),
    .out_status    (out_status),
    .out_count_out (out_count_out),
    .out_is_empty  (out_is_empty)
  );

endmodule
